>>> rtl/assert_macros.svh
// Assertion macros used by the copy back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/lzpd_pkg.sv
// Shared types and constants of the LZ prefix-code decompressor
package lzpd_pkg;

  localparam int DEF_WINDOW_DEPTH = 8192;
  localparam int DEF_OUT_LANES    = 8;

  localparam int OFS_W  = 13;
  localparam int LEN_W  = 9;
  localparam int BYTES_W = 64;

  localparam logic [7:0] BYTE_SKIP = 8'hFE;
  localparam logic [7:0] BYTE_END  = 8'hFF;
  localparam logic [4:0] LEN_ESC   = 5'd25;
  localparam logic [4:0] FU_AWAIT_LO = 5'd16;
  localparam logic [4:0] FU_AWAIT_HI = 5'd17;

  typedef enum logic [2:0] {
    PH_MODE,
    PH_LEN,
    PH_OFS,
    PH_LIT,
    PH_ESC,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_DONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       lit;
    logic [LEN_W-1:0] len;
    logic [OFS_W-1:0] ofs;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_DONE
  } back_state_t;

endpackage

>>> rtl/lzpd_cmd_queue.sv
// Two-entry command queue between parser front and copy back end
module lzpd_cmd_queue
  import lzpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic room,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  cmd_t       ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign room      = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_cmd   = ent_r[rptr_r];
  assign do_push   = push && room;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/lzpd_front.sv
// Parser front: flag words, prefix codes and command issue
module lzpd_front
  import lzpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_comp_byte,
  output logic       cmd_push,
  output cmd_t       cmd,
  input  logic       q_room
);

  logic [15:0]      fw_r, fw_nxt;
  logic [4:0]       fu_r, fu_nxt;
  phase_t           ph_r, ph_nxt;
  logic [8:0]       cb_r, cb_nxt;
  logic [3:0]       cc_r, cc_nxt;
  logic [LEN_W-1:0] mlen_r, mlen_nxt;
  logic [4:0]       ohi_r, ohi_nxt;
  logic             fin_r, fin_nxt;
  logic             walking, acc, bit_v;
  logic [8:0]       cb_sh;
  logic [3:0]       cc_inc;
  logic [5:0]       lhit, ohit;

  // {hit, value}; value 25 marks the escape
  function automatic logic [5:0] len_dec(input logic [3:0] n, input logic [8:0] b);
    logic [5:0] r;
    r = 6'd0;
    case (n)
      4'd2: if (b == 9'h002) r = {1'b1, 5'd2}; else if (b == 9'h003) r = {1'b1, 5'd3};
      4'd3: if (b == 9'h000) r = {1'b1, 5'd4};
      4'd4: if (b >= 9'h002 && b <= 9'h004) r = {1'b1, 5'(b + 9'd3)};
      4'd5: if (b >= 9'h00A && b <= 9'h00C) r = {1'b1, 5'(b - 9'd2)};
      4'd6: if (b == 9'h01A) r = {1'b1, 5'd11};
            else if (b == 9'h01B) r = {1'b1, 5'd12};
            else if (b == 9'h01C) r = {1'b1, LEN_ESC};
      4'd7: if (b >= 9'h03A && b <= 9'h03C) r = {1'b1, 5'(b - 9'h02D)};
      4'd8: if (b >= 9'h07A && b <= 9'h07C) r = {1'b1, 5'(b - 9'h06A)};
      4'd9: if (b >= 9'h0FA) r = {1'b1, 5'(b - 9'h0E7)};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] ofs_dec(input logic [3:0] n, input logic [8:0] b);
    logic [5:0] r;
    r = 6'd0;
    case (n)
      4'd1: if (b == 9'h001) r = {1'b1, 5'd0};
      4'd4: if (b <= 9'h001) r = {1'b1, 5'(b + 9'd1)};
      4'd5: if (b >= 9'h004 && b <= 9'h007) r = {1'b1, 5'(b - 9'd1)};
      4'd6: if (b >= 9'h010 && b <= 9'h016) r = {1'b1, 5'(b - 9'd9)};
      4'd7: if (b == 9'h02E) r = {1'b1, 5'd14};
            else if (b == 9'h02F) r = {1'b1, 5'd15};
            else if (b >= 9'h030 && b <= 9'h03F) r = {1'b1, 5'(b - 9'h020)};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  assign walking  = !fin_r && (fu_r < FU_AWAIT_LO) &&
                    (ph_r == PH_MODE || ph_r == PH_LEN || ph_r == PH_OFS);
  assign in_ready = fin_r || (!walking && q_room);
  assign acc      = in_valid && in_ready;
  assign bit_v    = fw_r[fu_r[3:0]];
  assign cb_sh    = {cb_r[7:0], bit_v};
  assign cc_inc   = cc_r + 4'd1;
  assign lhit     = len_dec(cc_inc, cb_sh);
  assign ohit     = ofs_dec(cc_inc, cb_sh);

  always_comb begin
    fw_nxt   = fw_r;
    fu_nxt   = fu_r;
    ph_nxt   = ph_r;
    cb_nxt   = cb_r;
    cc_nxt   = cc_r;
    mlen_nxt = mlen_r;
    ohi_nxt  = ohi_r;
    fin_nxt  = fin_r;
    cmd_push = 1'b0;
    cmd.kind = CMD_LIT;
    cmd.lit  = in_comp_byte;
    cmd.len  = mlen_r;
    cmd.ofs  = {ohi_r, in_comp_byte};
    if (acc && !fin_r) begin
      if (fu_r == FU_AWAIT_LO) begin
        fw_nxt = {fw_r[15:8], in_comp_byte};
        fu_nxt = FU_AWAIT_HI;
      end else if (fu_r >= FU_AWAIT_HI) begin
        fw_nxt = {in_comp_byte, fw_r[7:0]};
        fu_nxt = 5'd0;
      end else begin
        case (ph_r)
          PH_LIT: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_LIT;
            ph_nxt   = PH_MODE;
          end
          PH_ESC: begin
            if (in_comp_byte == BYTE_SKIP) begin
              ph_nxt = PH_MODE;
            end else if (in_comp_byte == BYTE_END) begin
              fin_nxt  = 1'b1;
              cmd_push = 1'b1;
              cmd.kind = CMD_DONE;
            end else begin
              mlen_nxt = LEN_W'(in_comp_byte) + LEN_W'(LEN_ESC);
              cb_nxt   = 9'd0;
              cc_nxt   = 4'd0;
              ph_nxt   = PH_OFS;
            end
          end
          PH_LOW: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_COPY;
            ph_nxt   = PH_MODE;
          end
          default: ph_nxt = ph_r;
        endcase
      end
    end else if (walking) begin
      fu_nxt = fu_r + 5'd1;
      case (ph_r)
        PH_MODE: begin
          if (bit_v) begin
            ph_nxt = PH_LEN;
            cb_nxt = 9'd0;
            cc_nxt = 4'd0;
          end else begin
            ph_nxt = PH_LIT;
          end
        end
        PH_LEN: begin
          cb_nxt = cb_sh;
          cc_nxt = cc_inc;
          if (!lhit[5]) begin
            if (cc_inc >= 4'd9) begin
              cb_nxt = 9'd0;
              cc_nxt = 4'd0;
            end
          end else if (lhit[4:0] == LEN_ESC) begin
            ph_nxt = PH_ESC;
          end else begin
            mlen_nxt = LEN_W'(lhit[4:0]);
            if (lhit[4:0] == 5'd2) begin
              ohi_nxt = 5'd0;
              ph_nxt  = PH_LOW;
            end else begin
              cb_nxt = 9'd0;
              cc_nxt = 4'd0;
              ph_nxt = PH_OFS;
            end
          end
        end
        PH_OFS: begin
          cb_nxt = cb_sh;
          cc_nxt = cc_inc;
          if (!ohit[5]) begin
            if (cc_inc >= 4'd7) begin
              cb_nxt = 9'd0;
              cc_nxt = 4'd0;
            end
          end else begin
            ohi_nxt = ohit[4:0];
            ph_nxt  = PH_LOW;
          end
        end
        default: ph_nxt = ph_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= 16'd0;
      fu_r   <= FU_AWAIT_LO;
      ph_r   <= PH_MODE;
      cb_r   <= 9'd0;
      cc_r   <= 4'd0;
      mlen_r <= '0;
      ohi_r  <= 5'd0;
      fin_r  <= 1'b0;
    end else begin
      fw_r   <= fw_nxt;
      fu_r   <= fu_nxt;
      ph_r   <= ph_nxt;
      cb_r   <= cb_nxt;
      cc_r   <= cc_nxt;
      mlen_r <= mlen_nxt;
      ohi_r  <= ohi_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

>>> rtl/lzpd_back.sv
// Copy back end: history window, byte packing and result register
`include "assert_macros.svh"
module lzpd_back
  import lzpd_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int OUT_LANES    = DEF_OUT_LANES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTES_W-1:0] out_bytes,
  output logic [3:0]         out_count,
  output logic               out_last_of_run,
  output logic               out_stream_done
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [7:0]         hist [WINDOW_DEPTH];
  logic [7:0]         rd_q;
  logic [AW-1:0]      rd_addr;

  back_state_t        st_r, st_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic               wrap_r, wrap_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [OFS_W-1:0]   ofs_r, ofs_nxt;
  logic [7:0]         lit_r, lit_nxt;
  logic               islit_r, islit_nxt;
  logic               srcok_r, srcok_nxt;
  logic [BYTES_W-1:0] pack_r, pack_nxt;
  logic [3:0]         pcnt_r, pcnt_nxt;
  logic               ov_r, ov_nxt;
  logic [BYTES_W-1:0] ob_r, ob_nxt;
  logic [3:0]         oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic               od_r, od_nxt;

  logic               slot_free, we, last_b, full_b;
  logic [7:0]         v;
  logic [AW:0]        diff, src;
  logic [BYTES_W-1:0] pack_add;

  assign slot_free = !ov_r || out_ready;
  assign diff      = {1'b0, wp_r} - (AW+1)'(ofs_r);
  assign src       = diff[AW] ? diff + (AW+1)'(WINDOW_DEPTH) : diff;
  assign rd_addr   = src[AW-1:0];
  assign v         = islit_r ? lit_r : (srcok_r ? rd_q : 8'd0);
  assign last_b    = (rem_r == LEN_W'(1));
  assign full_b    = (pcnt_r + 4'd1 == 4'(OUT_LANES));

  always_comb begin
    pack_add = pack_r;
    for (int k = 0; k < OUT_LANES; k++) begin
      if (pcnt_r == 4'(k)) pack_add[8*k +: 8] = v;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    wp_nxt    = wp_r;
    wrap_nxt  = wrap_r;
    rem_nxt   = rem_r;
    ofs_nxt   = ofs_r;
    lit_nxt   = lit_r;
    islit_nxt = islit_r;
    srcok_nxt = srcok_r;
    pack_nxt  = pack_r;
    pcnt_nxt  = pcnt_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    od_nxt    = od_r;
    we        = 1'b0;
    cmd_pop   = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          lit_nxt = cmd.lit;
          ofs_nxt = cmd.ofs;
          case (cmd.kind)
            CMD_LIT: begin
              islit_nxt = 1'b1;
              rem_nxt   = LEN_W'(1);
              st_nxt    = BK_WRITE;
            end
            CMD_COPY: begin
              islit_nxt = 1'b0;
              rem_nxt   = cmd.len;
              st_nxt    = BK_READ;
            end
            CMD_DONE: st_nxt = BK_DONE;
            default:  st_nxt = BK_IDLE;
          endcase
        end
      end
      BK_READ: begin
        srcok_nxt = (ofs_r != '0) && (wrap_r || rd_addr < wp_r);
        st_nxt    = BK_WRITE;
      end
      BK_WRITE: begin
        if (slot_free) begin
          we = 1'b1;
          if (wp_r == AW'(WINDOW_DEPTH - 1)) begin
            wp_nxt   = '0;
            wrap_nxt = 1'b1;
          end else begin
            wp_nxt = wp_r + AW'(1);
          end
          rem_nxt = rem_r - LEN_W'(1);
          if (last_b || full_b) begin
            ov_nxt   = 1'b1;
            ob_nxt   = pack_add;
            oc_nxt   = pcnt_r + 4'd1;
            ol_nxt   = last_b;
            od_nxt   = 1'b0;
            pack_nxt = '0;
            pcnt_nxt = 4'd0;
          end else begin
            pack_nxt = pack_add;
            pcnt_nxt = pcnt_r + 4'd1;
          end
          st_nxt = last_b ? BK_IDLE : BK_READ;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ob_nxt = '0;
          oc_nxt = 4'd0;
          ol_nxt = 1'b1;
          od_nxt = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      wp_r   <= '0;
      wrap_r <= 1'b0;
      pack_r <= '0;
      pcnt_r <= 4'd0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wp_r   <= wp_nxt;
      wrap_r <= wrap_nxt;
      pack_r <= pack_nxt;
      pcnt_r <= pcnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    ofs_r   <= ofs_nxt;
    lit_r   <= lit_nxt;
    islit_r <= islit_nxt;
    srcok_r <= srcok_nxt;
    ob_r    <= ob_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
    od_r    <= od_nxt;
  end

  always_ff @(posedge clk) begin
    rd_q <= hist[rd_addr];
    if (we) begin
      hist[wp_r] <= v;
    end
  end

  assign out_valid       = ov_r;
  assign out_bytes       = ob_r;
  assign out_count       = oc_r;
  assign out_last_of_run = ol_r;
  assign out_stream_done = od_r;

  `ASSERT_NEVER(a_count_range, clk, rst_n, ov_r && (oc_r > 4'(OUT_LANES)), "count over lanes")
  `ASSERT_IMPLIES(a_done_last, clk, rst_n, ov_r && od_r, ol_r && (oc_r == 4'd0), "bad end result")
  `ASSERT_IMPLIES(a_pack_idle, clk, rst_n, st_r == BK_IDLE, pcnt_r == 4'd0, "bytes left packed")

endmodule

>>> rtl/lz_prefix_code_decompressor.sv
// Top level of the LZ prefix-code decompressor
// Takes one compressed byte per item and returns decoded bytes packed up to OUT_LANES
// per result. The front decodes one flag bit per cycle and, until the end marker,
// takes a byte only when the current flag word needs one and the two-entry command
// queue has room; after the end marker it accepts every byte. A byte that completes
// a literal, a match or the end marker becomes a command. The back end pops each
// command in BK_IDLE, writes a literal byte in BK_WRITE and handles each copied byte
// in BK_READ (history read), then BK_WRITE (write and pack); BK_WRITE and BK_DONE
// wait while the result register is full and not taken. History is tracked by a write
// pointer and a wrap flag, so no clearing pass follows reset.
module lz_prefix_code_decompressor
  import lzpd_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int OUT_LANES    = DEF_OUT_LANES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_comp_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTES_W-1:0] out_bytes,
  output logic [3:0]         out_count,
  output logic               out_last_of_run,
  output logic               out_stream_done
);

  logic cmd_push, q_room, q_valid, q_pop;
  cmd_t cmd_in, cmd_out;

  lzpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_comp_byte (in_comp_byte),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .q_room       (q_room)
  );

  lzpd_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (cmd_in),
    .room      (q_room),
    .pop_valid (q_valid),
    .pop_cmd   (cmd_out),
    .pop       (q_pop)
  );

  lzpd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUT_LANES    (OUT_LANES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (cmd_out),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bytes       (out_bytes),
    .out_count       (out_count),
    .out_last_of_run (out_last_of_run),
    .out_stream_done (out_stream_done)
  );

endmodule
